// ----- rtl/core/sotv_pkg.sv -----
package sotv_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_OPCODE_LIMIT     = 2'd0;
    localparam logic [1:0] REG_MAX_ELEMENT_SIZE = 2'd1;

    // Reset values of the configuration registers
    localparam logic [7:0]  OPCODE_LIMIT_RESET     = 8'd211;
    localparam logic [15:0] MAX_ELEMENT_SIZE_RESET = 16'd520;

    // Byte roles
    localparam logic [1:0] ROLE_OPCODE = 2'd0;
    localparam logic [1:0] ROLE_LENGTH = 2'd1;
    localparam logic [1:0] ROLE_DATA   = 2'd2;

    // Error kinds
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED = 2'd1;
    localparam logic [1:0] ERR_OPCODE    = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd3;

    // Opcodes with special meaning
    localparam logic [7:0] OPC_PUSHDATA1 = 8'h4c;
    localparam logic [7:0] OPC_PUSHDATA2 = 8'h4d;
    localparam logic [7:0] OPC_PUSHDATA4 = 8'h4e;
    localparam logic [7:0] OPC_LAST_PUSH = 8'h60;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic [7:0]  data_byte;
        logic [7:0]  current_opcode;
        logic [31:0] push_length;
        logic        op_done;
        logic        script_done;
        logic [1:0]  error_kind;
        logic        script_valid;
        logic        push_only;
    } result_item_t;

    // Number of little-endian length bytes after a pushdata opcode
    function automatic logic [2:0] length_field_bytes(input logic [7:0] opc);
        logic [2:0] n;
        if (opc == OPC_PUSHDATA1) begin
            n = 3'd1;
        end else if (opc == OPC_PUSHDATA2) begin
            n = 3'd2;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/script_op_tokenizer_validator.sv -----
// Script operation tokenizer and validator.
// Input channel byte_valid/byte_ready/byte_beat carries one script byte and a
// last_byte flag per beat. Each accepted beat yields exactly one result beat on
// result_valid/result_ready/result_beat: the byte's role, the byte, the opcode
// and push length of its operation, op_done, and on the last byte
// (script_done) the latched verdict: error_kind, script_valid, push_only.
// Configuration beats on cfg_valid/cfg_ready write the opcode limit (index 0)
// or max_element_size (index 1); cfg_ready is always high. Write only when idle.
// Throughput: one byte per cycle while the skid entry is empty; the per-byte
// parse step is a single combinational pass between the parse state registers
// and the result register.
// Stall: a result register plus one skid entry sit on the output; when the
// receiver stalls, one more byte is taken into the skid entry and byte_ready
// then falls until the result register drains.
// Reset: parse state returns to "expecting opcode", verdict flags to valid and
// push-only, both output entries empty, configuration to 211 and 520.
// After the last byte of a script the parse state clears for the next script.
module script_op_tokenizer_validator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  sotv_pkg::byte_item_t  byte_beat,
    output logic                  result_valid,
    input  logic                  result_ready,
    output sotv_pkg::result_item_t result_beat,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam logic [1:0] PHASE_OPCODE = 2'd0;
    localparam logic [1:0] PHASE_LENGTH = 2'd1;
    localparam logic [1:0] PHASE_DATA   = 2'd2;
    localparam logic [1:0] PHASE_DRAIN  = 2'd3;

    logic [7:0]  opcode_limit_reg;
    logic [15:0] max_element_size_reg;

    logic [1:0]  phase_reg,        phase_next;
    logic [7:0]  held_opcode_reg,  held_opcode_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [2:0]  length_left_reg,  length_left_next;
    logic [31:0] data_left_reg,    data_left_next;
    logic        valid_flag_reg,   valid_flag_next;
    logic        push_only_reg,    push_only_next;
    logic [1:0]  first_error_reg,  first_error_next;

    sotv_pkg::result_item_t result_next;
    sotv_pkg::result_item_t out_reg;
    sotv_pkg::result_item_t skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;

    logic        accept;
    logic        out_free;
    logic [7:0]  b;
    logic        last;
    logic [1:0]  role;
    logic [7:0]  opc;
    logic [31:0] plen;
    logic        done;
    logic [2:0]  total;
    logic [1:0]  idx;
    logic [31:0] accum_merged;
    logic [2:0]  length_left_dec;
    logic [31:0] data_left_dec;

    assign cfg_ready    = 1'b1;
    assign byte_ready   = !skid_valid_reg;
    assign accept       = byte_valid && byte_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result_beat  = out_reg;

    assign b    = byte_beat.script_byte;
    assign last = byte_beat.last_byte;

    assign total           = sotv_pkg::length_field_bytes(held_opcode_reg);
    assign idx             = 2'(total - length_left_reg);
    assign accum_merged    = length_accum_reg | (32'(b) << {idx, 3'b000});
    assign length_left_dec = length_left_reg - 3'd1;
    assign data_left_dec   = data_left_reg - 32'd1;

    // Parse one byte and update the per-script state
    always_comb
    begin
        role              = sotv_pkg::ROLE_OPCODE;
        opc               = 8'd0;
        plen              = 32'd0;
        done              = 1'b0;
        phase_next        = phase_reg;
        held_opcode_next  = held_opcode_reg;
        length_accum_next = length_accum_reg;
        length_left_next  = length_left_reg;
        data_left_next    = data_left_reg;
        valid_flag_next   = valid_flag_reg;
        push_only_next    = push_only_reg;
        first_error_next  = first_error_reg;

        case (phase_reg)
            PHASE_OPCODE:
            begin
                opc              = b;
                held_opcode_next = b;
                if (b < sotv_pkg::OPC_PUSHDATA1) begin
                    plen              = 32'(b);
                    length_accum_next = 32'(b);
                    if (b == 8'd0) begin
                        done = 1'b1;
                    end else begin
                        data_left_next = 32'(b);
                        phase_next     = PHASE_DATA;
                    end
                end else if (b <= sotv_pkg::OPC_PUSHDATA4) begin
                    length_accum_next = 32'd0;
                    length_left_next  = sotv_pkg::length_field_bytes(b);
                    phase_next        = PHASE_LENGTH;
                end else begin
                    done = 1'b1;
                end
            end
            PHASE_LENGTH:
            begin
                role              = sotv_pkg::ROLE_LENGTH;
                opc               = held_opcode_reg;
                length_accum_next = accum_merged;
                plen              = accum_merged;
                if (length_left_reg != 3'd0) begin
                    length_left_next = length_left_dec;
                end
                if (length_left_reg <= 3'd1) begin
                    if (accum_merged == 32'd0) begin
                        done = 1'b1;
                    end else begin
                        data_left_next = accum_merged;
                        phase_next     = PHASE_DATA;
                    end
                end
            end
            PHASE_DATA:
            begin
                role = sotv_pkg::ROLE_DATA;
                opc  = held_opcode_reg;
                plen = length_accum_reg;
                if (data_left_reg != 32'd0) begin
                    data_left_next = data_left_dec;
                end
                if (data_left_reg <= 32'd1) begin
                    done = 1'b1;
                end
            end
            default:
            begin
                // drain: pass over the rest of a failed script until its last byte
            end
        endcase

        // Check the completed operation, or flag a cut-short script
        if (done) begin
            phase_next = PHASE_OPCODE;
            if (opc > sotv_pkg::OPC_LAST_PUSH) begin
                push_only_next = 1'b0;
            end
            if (opc > opcode_limit_reg) begin
                valid_flag_next  = 1'b0;
                first_error_next = sotv_pkg::ERR_OPCODE;
                phase_next       = PHASE_DRAIN;
            end else if (plen > 32'(max_element_size_reg)) begin
                valid_flag_next  = 1'b0;
                first_error_next = sotv_pkg::ERR_TOO_LONG;
                phase_next       = PHASE_DRAIN;
            end
        end else if (last && phase_reg != PHASE_DRAIN) begin
            valid_flag_next  = 1'b0;
            first_error_next = sotv_pkg::ERR_TRUNCATED;
            push_only_next   = 1'b0;
        end

        result_next.byte_role      = role;
        result_next.data_byte      = b;
        result_next.current_opcode = opc;
        result_next.push_length    = plen;
        result_next.op_done        = done;
        result_next.script_done    = last;
        result_next.error_kind     = first_error_next;
        result_next.script_valid   = valid_flag_next;
        result_next.push_only      = push_only_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            opcode_limit_reg     <= sotv_pkg::OPCODE_LIMIT_RESET;
            max_element_size_reg <= sotv_pkg::MAX_ELEMENT_SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                sotv_pkg::REG_OPCODE_LIMIT:     opcode_limit_reg     <= cfg_data[7:0];
                sotv_pkg::REG_MAX_ELEMENT_SIZE: max_element_size_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // Advance parse state on each accepted byte; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PHASE_OPCODE;
            held_opcode_reg  <= 8'd0;
            length_accum_reg <= 32'd0;
            length_left_reg  <= 3'd0;
            data_left_reg    <= 32'd0;
            valid_flag_reg   <= 1'b1;
            push_only_reg    <= 1'b1;
            first_error_reg  <= sotv_pkg::ERR_NONE;
        end else if (accept) begin
            if (last) begin
                phase_reg        <= PHASE_OPCODE;
                held_opcode_reg  <= 8'd0;
                length_accum_reg <= 32'd0;
                length_left_reg  <= 3'd0;
                data_left_reg    <= 32'd0;
                valid_flag_reg   <= 1'b1;
                push_only_reg    <= 1'b1;
                first_error_reg  <= sotv_pkg::ERR_NONE;
            end else begin
                phase_reg        <= phase_next;
                held_opcode_reg  <= held_opcode_next;
                length_accum_reg <= length_accum_next;
                length_left_reg  <= length_left_next;
                data_left_reg    <= data_left_next;
                valid_flag_reg   <= valid_flag_next;
                push_only_reg    <= push_only_next;
                first_error_reg  <= first_error_next;
            end
        end
    end

    // Output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload of the output register and skid entry
    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result_next;
            end
        end else if (accept) begin
            skid_reg <= result_next;
        end
    end

endmodule

// ----- sim/tb_script_op_tokenizer_validator.sv -----
`timescale 1ns / 100ps

module tb_script_op_tokenizer_validator;

    import sotv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int PROBE_COUNT = 25;
    localparam int BEATS_PER_PHASE = 130;
    localparam int HOLD_AFTER = 350;
    localparam int HOLD_CYCLES = 200;

    typedef enum logic [1:0] {AT_OPCODE, AT_LENGTH, AT_DATA, AT_DRAIN} parse_phase_t;

    typedef struct packed {
        logic         new_limits;
        logic [7:0]   lim_op;
        logic [15:0]  lim_len;
        byte_item_t   stim;
        logic         typed;
        result_item_t want;
    } probe_row_t;

    localparam result_item_t UNTYPED = '0;

    // Directed probes; typed rows carry their result, the rest go through the predictor
    localparam probe_row_t PROBES [PROBE_COUNT] = '{
        // lone opcodes at the reset limits
        '{1'b0, 8'h00, 16'h0000, '{8'h00, 1'b1}, 1'b1,
          '{ROLE_OPCODE, 8'h00, 8'h00, 32'h0, 1'b1, 1'b1, ERR_NONE, 1'b1, 1'b1}},
        '{1'b0, 8'h00, 16'h0000, '{8'hff, 1'b1}, 1'b1,
          '{ROLE_OPCODE, 8'hff, 8'hff, 32'h0, 1'b1, 1'b1, ERR_OPCODE, 1'b0, 1'b0}},
        '{1'b0, 8'h00, 16'h0000, '{8'h61, 1'b1}, 1'b1,
          '{ROLE_OPCODE, 8'h61, 8'h61, 32'h0, 1'b1, 1'b1, ERR_NONE, 1'b1, 1'b0}},
        '{1'b0, 8'h00, 16'h0000, '{8'h60, 1'b1}, 1'b1,
          '{ROLE_OPCODE, 8'h60, 8'h60, 32'h0, 1'b1, 1'b1, ERR_NONE, 1'b1, 1'b1}},
        // one-byte length push of two bytes
        '{1'b0, 8'h00, 16'h0000, '{8'h4c, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h02, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'haa, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h55, 1'b1}, 1'b0, UNTYPED},
        // two-byte length of zero ends on its last length byte
        '{1'b0, 8'h00, 16'h0000, '{8'h4d, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h00, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h00, 1'b1}, 1'b0, UNTYPED},
        // full-scale four-byte length, cut off by the script end
        '{1'b0, 8'h00, 16'h0000, '{8'h4e, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'hff, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'hff, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'hff, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'hff, 1'b1}, 1'b1,
          '{ROLE_LENGTH, 8'hff, 8'h4e, 32'hffffffff, 1'b0, 1'b1, ERR_TRUNCATED,
            1'b0, 1'b0}},
        // direct push cut short
        '{1'b0, 8'h00, 16'h0000, '{8'h03, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h11, 1'b1}, 1'b0, UNTYPED},
        // tight limits: push over the element size
        '{1'b1, 8'h60, 16'h0001, '{8'h02, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h7f, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h80, 1'b1}, 1'b1,
          '{ROLE_DATA, 8'h80, 8'h02, 32'h2, 1'b1, 1'b1, ERR_TOO_LONG, 1'b0, 1'b1}},
        // opcode over the limit, then a drained byte
        '{1'b0, 8'h00, 16'h0000, '{8'h61, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h00, 1'b1}, 1'b1,
          '{ROLE_OPCODE, 8'h00, 8'h00, 32'h0, 1'b0, 1'b1, ERR_OPCODE, 1'b0, 1'b0}},
        // one-byte length of zero
        '{1'b0, 8'h00, 16'h0000, '{8'h4c, 1'b0}, 1'b0, UNTYPED},
        '{1'b0, 8'h00, 16'h0000, '{8'h00, 1'b1}, 1'b1,
          '{ROLE_LENGTH, 8'h00, OPC_PUSHDATA1, 32'h0, 1'b1, 1'b1, ERR_NONE, 1'b1, 1'b1}}
    };

    logic         clk = 1'b0;
    logic         rst_n;
    logic         byte_valid;
    logic         byte_ready;
    byte_item_t   byte_beat;
    logic         result_valid;
    logic         result_ready;
    result_item_t result_beat;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    // Predictor state and its copy of the limits
    parse_phase_t phase_q;
    logic [7:0]   held_op;
    logic [31:0]  length_sum;
    logic [2:0]   length_togo;
    logic [2:0]   length_width;
    logic [31:0]  data_togo;
    logic         verdict_ok;
    logic         verdict_po;
    logic [1:0]   verdict_err;
    logic [7:0]   cap_opcode;
    logic [15:0]  cap_size;

    result_item_t awaited_tokens [$];
    logic [7:0]   script_bytes [$];
    int unsigned  parsed_beats = 0;
    int unsigned  phase_beats = 0;
    int unsigned  misses = 0;
    int unsigned  ticks = 0;
    logic         quiet = 1'b0;
    logic         hold_done = 1'b0;

    script_op_tokenizer_validator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_beat    (byte_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void restart_script();
        phase_q      = AT_OPCODE;
        held_op      = '0;
        length_sum   = '0;
        length_togo  = '0;
        length_width = '0;
        data_togo    = '0;
        verdict_ok   = 1'b1;
        verdict_po   = 1'b1;
        verdict_err  = ERR_NONE;
    endfunction

    // Advance the parse by one byte and return the token it yields
    function automatic result_item_t tokenize_byte(input byte_item_t stim);
        result_item_t r;
        logic [7:0]   b;
        logic         fin;
        logic [1:0]   slot;
        b = stim.script_byte;
        r = '0;
        r.byte_role = ROLE_OPCODE;
        r.data_byte = b;
        fin = 1'b0;
        case (phase_q)
            AT_OPCODE: begin
                r.current_opcode = b;
                held_op = b;
                if (b < OPC_PUSHDATA1) begin
                    r.push_length = {24'h0, b};
                    length_sum = {24'h0, b};
                    if (b == 8'h00) begin
                        fin = 1'b1;
                    end else begin
                        data_togo = {24'h0, b};
                        phase_q = AT_DATA;
                    end
                end else if (b <= OPC_PUSHDATA4) begin
                    length_sum = '0;
                    length_width = (b == OPC_PUSHDATA1) ? 3'd1 :
                                   (b == OPC_PUSHDATA2) ? 3'd2 : 3'd4;
                    length_togo = length_width;
                    phase_q = AT_LENGTH;
                end else begin
                    fin = 1'b1;
                end
            end
            AT_LENGTH: begin
                slot = 2'(length_width - length_togo);
                r.byte_role = ROLE_LENGTH;
                r.current_opcode = held_op;
                length_sum = length_sum | ({24'h0, b} << {slot, 3'b000});
                if (length_togo != 0) length_togo = length_togo - 3'd1;
                r.push_length = length_sum;
                if (length_togo == 0) begin
                    if (length_sum == 0) begin
                        fin = 1'b1;
                    end else begin
                        data_togo = length_sum;
                        phase_q = AT_DATA;
                    end
                end
            end
            AT_DATA: begin
                r.byte_role = ROLE_DATA;
                r.current_opcode = held_op;
                r.push_length = length_sum;
                if (data_togo != 0) data_togo = data_togo - 32'd1;
                if (data_togo == 0) fin = 1'b1;
            end
            default: ;
        endcase

        // Judge a finished operation, or latch truncation on the script end
        if (fin) begin
            phase_q = AT_OPCODE;
            if (r.current_opcode > OPC_LAST_PUSH) verdict_po = 1'b0;
            if (r.current_opcode > cap_opcode) begin
                verdict_ok = 1'b0;
                verdict_err = ERR_OPCODE;
                phase_q = AT_DRAIN;
            end else if (r.push_length > {16'h0, cap_size}) begin
                verdict_ok = 1'b0;
                verdict_err = ERR_TOO_LONG;
                phase_q = AT_DRAIN;
            end
        end else if (stim.last_byte && phase_q != AT_DRAIN) begin
            verdict_ok = 1'b0;
            verdict_err = ERR_TRUNCATED;
            verdict_po = 1'b0;
        end
        r.op_done = fin;
        r.script_done = stim.last_byte;
        r.error_kind = verdict_err;
        r.script_valid = verdict_ok;
        r.push_only = verdict_po;
        if (stim.last_byte) restart_script();
        return r;
    endfunction

    function automatic string show_token(input result_item_t t);
        return $sformatf("role=%0d byte=%02h op=%02h len=%08h done=%0b end=%0b err=%0d ok=%0b po=%0b",
                         t.byte_role, t.data_byte, t.current_opcode, t.push_length,
                         t.op_done, t.script_done, t.error_kind, t.script_valid,
                         t.push_only);
    endfunction

    // Build one script: mostly well-formed operations, some noise or cut short
    function automatic void compose_script();
        int          ops;
        int          kind;
        int          len;
        int          cut;
        logic [31:0] wide;
        script_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) script_bytes.push_back(8'($urandom));
            return;
        end
        ops = $urandom_range(1, 5);
        repeat (ops) begin
            len = $urandom_range(0, 6);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 75);
                    script_bytes.push_back(8'(len));
                end
                2: begin
                    script_bytes.push_back(OPC_PUSHDATA1);
                    script_bytes.push_back(8'(len));
                end
                3: begin
                    script_bytes.push_back(OPC_PUSHDATA2);
                    script_bytes.push_back(8'(len));
                    script_bytes.push_back(8'h00);
                end
                4: begin
                    script_bytes.push_back(OPC_PUSHDATA4);
                    script_bytes.push_back(8'(len));
                    repeat (3) script_bytes.push_back(8'h00);
                end
                default: script_bytes.push_back(8'($urandom_range(8'h4f, 8'hff)));
            endcase
            if (kind <= 4) repeat (len) script_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, script_bytes.size());
            while (script_bytes.size() > cut) void'(script_bytes.pop_back());
        end else if ($urandom_range(0, 7) == 0) begin
            // leave a wide length hanging at the script end
            wide = $urandom;
            if ($urandom_range(0, 1) == 1) begin
                script_bytes.push_back(OPC_PUSHDATA4);
                script_bytes.push_back(wide[7:0]);
                script_bytes.push_back(wide[15:8]);
                script_bytes.push_back(wide[23:16]);
                script_bytes.push_back(wide[31:24]);
            end else begin
                script_bytes.push_back(OPC_PUSHDATA2);
                script_bytes.push_back(wide[7:0]);
                script_bytes.push_back(wide[15:8]);
            end
            repeat ($urandom_range(0, 3)) script_bytes.push_back(8'($urandom));
        end
    endfunction

    // Offer one byte, hold it until taken, then log the token it should yield
    task automatic offer_byte(input byte_item_t stim, input logic typed,
                              input result_item_t want);
        int           gap;
        result_item_t predicted;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            byte_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat  <= stim;
        do @(posedge clk); while (byte_ready !== 1'b1);
        phase_beats++;
        parsed_beats++;
        predicted = tokenize_byte(stim);
        awaited_tokens.push_back(typed ? want : predicted);
    endtask

    // Drain the block, then write both limits back to back
    task automatic apply_limits(input logic [7:0] op_lim, input logic [15:0] len_lim);
        byte_valid <= 1'b0;
        while (awaited_tokens.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_OPCODE_LIMIT;
        cfg_data  <= {8'h00, op_lim};
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cap_opcode = op_lim;
        cfg_index <= REG_MAX_ELEMENT_SIZE;
        cfg_data  <= len_lim;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cap_size = len_lim;
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial begin
        byte_item_t stim;
        int         p;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_beat  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_OPCODE_LIMIT;
        cfg_data   <= '0;
        cap_opcode = OPCODE_LIMIT_RESET;
        cap_size   = MAX_ELEMENT_SIZE_RESET;
        restart_script();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < PROBE_COUNT; k++) begin
            if (PROBES[k].new_limits) apply_limits(PROBES[k].lim_op, PROBES[k].lim_len);
            offer_byte(PROBES[k].stim, PROBES[k].typed, PROBES[k].want);
        end

        for (p = 0; p < 5; p++) begin
            case (p)
                0: apply_limits(8'hff, 16'hffff);
                1: apply_limits(8'h00, 16'h0000);
                2: apply_limits(8'($urandom_range(8'h4f, 8'hd3)), 16'($urandom_range(0, 8)));
                3: apply_limits(OPCODE_LIMIT_RESET, MAX_ELEMENT_SIZE_RESET);
                default: begin
                    quiet = 1'b1;
                    apply_limits(8'($urandom), 16'($urandom_range(0, 6)));
                end
            endcase
            phase_beats = 0;
            while (phase_beats < BEATS_PER_PHASE) begin
                compose_script();
                foreach (script_bytes[i]) begin
                    stim.script_byte = script_bytes[i];
                    stim.last_byte = (i == script_bytes.size() - 1);
                    offer_byte(stim, 1'b0, UNTYPED);
                end
            end
        end

        byte_valid <= 1'b0;
        while (awaited_tokens.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (misses == 0 && awaited_tokens.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random stalls, plus one long hold-off to back up the input
    initial begin
        int span;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!hold_done && parsed_beats >= HOLD_AFTER && byte_valid) begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                result_ready <= 1'b0;
                span = $urandom_range(1, 15);
                repeat (span) @(posedge clk);
                result_ready <= 1'b1;
            end else begin
                result_ready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest expected token
    always @(posedge clk) begin
        result_item_t want;
        result_item_t got;
        logic         wrong;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_ready === 1'b1) begin
            got = result_beat;
            if (awaited_tokens.size() == 0) begin
                if (misses < 10) $display("unexpected token: %s", show_token(got));
                misses++;
            end else begin
                want = awaited_tokens.pop_front();
                wrong = (got.byte_role !== want.byte_role)
                     || (got.data_byte !== want.data_byte)
                     || (got.current_opcode !== want.current_opcode)
                     || (got.push_length !== want.push_length)
                     || (got.op_done !== want.op_done)
                     || (got.script_done !== want.script_done)
                     || (got.error_kind !== want.error_kind)
                     || (got.script_valid !== want.script_valid)
                     || (got.push_only !== want.push_only);
                if (wrong) begin
                    if (misses < 10) begin
                        $display("mismatch, expected %s", show_token(want));
                        $display("           actual %s", show_token(got));
                    end
                    misses++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        ticks <= ticks + 1;
        if (ticks == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
